// File: sv/htff_pkg.sv
package htff_pkg;

    // Image geometry limits
    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int PIXEL_BITS = 8;

    localparam int MAX_PIXELS = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W     = $clog2(MAX_PIXELS);
    localparam int CNT_W      = ADDR_W + 1;
    localparam int X_W        = $clog2(MAX_WIDTH);
    localparam int Y_W        = $clog2(MAX_HEIGHT);
    localparam int Q_W        = X_W + Y_W;

    // Port widths fixed by the register map and item fields
    localparam int THR_W      = 8;
    localparam int DIM_W      = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int PIX_IN_W   = 8;
    localparam int COORD_W    = DIM_W + 1;
    localparam int CMP_W      = 16;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LOW_THRESHOLD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 2'd3;

    // Command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // Reset values of the registers
    localparam logic [THR_W-1:0] LOW_THRESHOLD_RST  = 8'd77;
    localparam logic [THR_W-1:0] HIGH_THRESHOLD_RST = 8'd153;
    localparam logic [DIM_W-1:0] IMAGE_WIDTH_RST    = 9'd256;
    localparam logic [DIM_W-1:0] IMAGE_HEIGHT_RST   = 9'd256;

    localparam logic [2:0] NB_LAST = 3'd7;

    // Column step of neighbor k (the eight around the center)
    function automatic logic signed [1:0] nb_dx(input logic [2:0] k);
        logic signed [1:0] d;
        case (k)
            3'd0, 3'd3, 3'd5: d = -2'sd1;
            3'd1, 3'd6:       d = 2'sd0;
            default:          d = 2'sd1;
        endcase
        return d;
    endfunction

    // Row step of neighbor k
    function automatic logic signed [1:0] nb_dy(input logic [2:0] k);
        logic signed [1:0] d;
        case (k)
            3'd0, 3'd1, 3'd2: d = -2'sd1;
            3'd3, 3'd4:       d = 2'sd0;
            default:          d = 2'sd1;
        endcase
        return d;
    endfunction

    // Row slot (0 above, 1 same, 2 below) of neighbor k
    function automatic logic [1:0] nb_row(input logic [2:0] k);
        logic [1:0] r;
        case (k)
            3'd0, 3'd1, 3'd2: r = 2'd0;
            3'd3, 3'd4:       r = 2'd1;
            default:          r = 2'd2;
        endcase
        return r;
    endfunction

endpackage

// File: sv/hysteresis_threshold_flood_fill.sv
// Hysteresis edge tracking over one image plane. Pixels are loaded in
// row-major order with s_cmd = load, one transaction per cycle while s_ready
// is high. When the pixel count (clamped image_width * image_height) is
// reached, a seed scan and queue-driven 8-neighbor flood fill run on a single
// sequencer; s_ready stays low until it ends. The scan steps each pixel
// through ST_SCAN, ST_SCANQ and ST_POP; each marked pixel is popped and its
// eight neighbors are visited in turn. The first load of each image, and
// reset, start a mark-map clearing pass over all 65536 entries, one entry
// per cycle, with s_ready low. For a mark read, m_valid is set from ST_RDQ,
// after the registered read of the mark memory, once the output slot is
// free; loads are still accepted while a result waits on m_ready. After a
// register write, s_ready drops for one cycle while the pixel count settles.
module hysteresis_threshold_flood_fill (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wen,
    input  logic [htff_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [htff_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_cmd,
    input  logic [htff_pkg::PIX_IN_W-1:0]    s_pixel_value,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_edge_mark,
    output logic                             m_last_mark
);

    localparam int ADDR_W  = htff_pkg::ADDR_W;
    localparam int CNT_W   = htff_pkg::CNT_W;
    localparam int X_W     = htff_pkg::X_W;
    localparam int Y_W     = htff_pkg::Y_W;
    localparam int Q_W     = htff_pkg::Q_W;
    localparam int DIM_W   = htff_pkg::DIM_W;
    localparam int THR_W   = htff_pkg::THR_W;
    localparam int PIX_W   = htff_pkg::PIXEL_BITS;
    localparam int COORD_W = htff_pkg::COORD_W;
    localparam int CMP_W   = htff_pkg::CMP_W;
    localparam int DEPTH   = htff_pkg::MAX_PIXELS;

    typedef enum logic [10:0] {
        ST_CLEAR = 11'b000_0000_0001,
        ST_IDLE  = 11'b000_0000_0010,
        ST_RD    = 11'b000_0000_0100,
        ST_RDQ   = 11'b000_0000_1000,
        ST_SCAN  = 11'b000_0001_0000,
        ST_SCANQ = 11'b000_0010_0000,
        ST_POP   = 11'b000_0100_0000,
        ST_POPQ  = 11'b000_1000_0000,
        ST_ROWS  = 11'b001_0000_0000,
        ST_NB    = 11'b010_0000_0000,
        ST_NBQ   = 11'b100_0000_0000
    } state_t;

    // Memories
    logic [PIX_W-1:0] pixel_mem [DEPTH];
    logic             mark_mem  [DEPTH];
    logic [Q_W-1:0]   queue_mem [DEPTH];

    // Registers
    state_t             state_reg, state_next;
    logic [ADDR_W-1:0]  clr_addr_reg, clr_addr_next;
    logic               fill_pending_reg, fill_pending_next;
    logic [CNT_W-1:0]   load_count_reg, load_count_next;
    logic [CNT_W-1:0]   read_count_reg, read_count_next;
    logic [CNT_W-1:0]   rd_pos_reg, rd_pos_next;
    logic [CNT_W-1:0]   seed_scan_reg, seed_scan_next;
    logic [X_W-1:0]     seed_x_reg, seed_x_next;
    logic [Y_W-1:0]     seed_y_reg, seed_y_next;
    logic [CNT_W-1:0]   head_reg, head_next;
    logic [CNT_W-1:0]   tail_reg, tail_next;
    logic [X_W-1:0]     cx_reg, cx_next;
    logic [Y_W-1:0]     cy_reg, cy_next;
    logic [CNT_W-1:0]   c_lin_reg, c_lin_next;
    logic [CNT_W-1:0]   row_base_reg [3];
    logic [CNT_W-1:0]   row_base_next [3];
    logic [2:0]         nb_k_reg, nb_k_next;
    logic [ADDR_W-1:0]  nb_addr_reg, nb_addr_next;
    logic [X_W-1:0]     nx_reg, nx_next;
    logic [Y_W-1:0]     ny_reg, ny_next;
    logic [THR_W-1:0]   low_thr_reg, high_thr_reg;
    logic [DIM_W-1:0]   width_reg, height_reg;
    logic [CNT_W-1:0]   total_reg;
    logic               cfg_settle_reg;
    logic               m_valid_reg, m_valid_next;
    logic               m_edge_mark_reg, m_edge_mark_next;
    logic               m_last_mark_reg, m_last_mark_next;

    // Memory ports
    logic [PIX_W-1:0]   pix_q;
    logic               mark_q;
    logic [Q_W-1:0]     queue_q;
    logic               pix_we;
    logic [ADDR_W-1:0]  pix_raddr;
    logic               mark_we;
    logic [ADDR_W-1:0]  mark_waddr, mark_raddr;
    logic               mark_wdata;
    logic               q_we;
    logic [Q_W-1:0]     q_wdata;

    // Working values
    logic [DIM_W-1:0]   w_eff, h_eff;
    logic [CNT_W-1:0]   load_inc, rd_inc;
    logic               load_fill;
    logic [CMP_W-1:0]   pix_cmp, low_cmp, high_cmp;
    logic               above_low, seed_ok, nb_ok, out_free;
    logic signed [1:0]  nb_dx_s, nb_dy_s;
    logic signed [COORD_W-1:0] nx_s, ny_s;
    logic               nb_in;
    logic [CNT_W-1:0]   nb_addr_full;
    logic [X_W-1:0]     q_cx;
    logic [Y_W-1:0]     q_cy;

    // Size registers clamped to the supported range
    always_comb begin
        if (width_reg == '0) begin
            w_eff = DIM_W'(1);
        end else if (width_reg > DIM_W'(htff_pkg::MAX_WIDTH)) begin
            w_eff = DIM_W'(htff_pkg::MAX_WIDTH);
        end else begin
            w_eff = width_reg;
        end
        if (height_reg == '0) begin
            h_eff = DIM_W'(1);
        end else if (height_reg > DIM_W'(htff_pkg::MAX_HEIGHT)) begin
            h_eff = DIM_W'(htff_pkg::MAX_HEIGHT);
        end else begin
            h_eff = height_reg;
        end
    end

    // Configuration registers and registered pixel count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_thr_reg    <= htff_pkg::LOW_THRESHOLD_RST;
            high_thr_reg   <= htff_pkg::HIGH_THRESHOLD_RST;
            width_reg      <= htff_pkg::IMAGE_WIDTH_RST;
            height_reg     <= htff_pkg::IMAGE_HEIGHT_RST;
            cfg_settle_reg <= 1'b1;
        end else begin
            cfg_settle_reg <= cfg_wen;
            if (cfg_wen) begin
                case (cfg_index)
                    htff_pkg::REG_LOW_THRESHOLD:  low_thr_reg  <= cfg_wdata[THR_W-1:0];
                    htff_pkg::REG_HIGH_THRESHOLD: high_thr_reg <= cfg_wdata[THR_W-1:0];
                    htff_pkg::REG_IMAGE_WIDTH:    width_reg    <= cfg_wdata[DIM_W-1:0];
                    htff_pkg::REG_IMAGE_HEIGHT:   height_reg   <= cfg_wdata[DIM_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        total_reg <= CNT_W'(w_eff) * CNT_W'(h_eff);
    end

    // Threshold compares on the pixel read back
    assign pix_cmp   = CMP_W'(pix_q);
    assign low_cmp   = CMP_W'(low_thr_reg);
    assign high_cmp  = CMP_W'(high_thr_reg);
    assign above_low = pix_cmp > low_cmp;
    assign seed_ok   = above_low && (pix_cmp >= high_cmp) && !mark_q;
    assign nb_ok     = above_low && !mark_q;

    // Neighbor position and bounds
    assign nb_dx_s = htff_pkg::nb_dx(nb_k_reg);
    assign nb_dy_s = htff_pkg::nb_dy(nb_k_reg);
    assign nx_s    = $signed(COORD_W'(cx_reg)) + COORD_W'(nb_dx_s);
    assign ny_s    = $signed(COORD_W'(cy_reg)) + COORD_W'(nb_dy_s);
    assign nb_in   = !nx_s[COORD_W-1] && !ny_s[COORD_W-1]
                     && (nx_s < $signed({1'b0, w_eff}))
                     && (ny_s < $signed({1'b0, h_eff}));
    assign nb_addr_full = row_base_reg[htff_pkg::nb_row(nb_k_reg)] + CNT_W'(nb_dx_s);

    assign q_cx     = queue_q[X_W-1:0];
    assign q_cy     = queue_q[Q_W-1:X_W];
    assign load_inc = load_count_reg + CNT_W'(1);
    assign load_fill = load_inc >= total_reg;
    assign rd_inc   = rd_pos_reg + CNT_W'(1);
    assign out_free = !m_valid_reg || m_ready;

    assign s_ready     = (state_reg == ST_IDLE) && !cfg_settle_reg;
    assign m_valid     = m_valid_reg;
    assign m_edge_mark = m_edge_mark_reg;
    assign m_last_mark = m_last_mark_reg;

    // Sequencer
    always_comb begin
        state_next        = state_reg;
        clr_addr_next     = clr_addr_reg;
        fill_pending_next = fill_pending_reg;
        load_count_next   = load_count_reg;
        read_count_next   = read_count_reg;
        rd_pos_next       = rd_pos_reg;
        seed_scan_next    = seed_scan_reg;
        seed_x_next       = seed_x_reg;
        seed_y_next       = seed_y_reg;
        head_next         = head_reg;
        tail_next         = tail_reg;
        cx_next           = cx_reg;
        cy_next           = cy_reg;
        c_lin_next        = c_lin_reg;
        row_base_next     = row_base_reg;
        nb_k_next         = nb_k_reg;
        nb_addr_next      = nb_addr_reg;
        nx_next           = nx_reg;
        ny_next           = ny_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_edge_mark_next  = m_edge_mark_reg;
        m_last_mark_next  = m_last_mark_reg;

        pix_we     = 1'b0;
        pix_raddr  = nb_addr_full[ADDR_W-1:0];
        mark_we    = 1'b0;
        mark_waddr = nb_addr_reg;
        mark_wdata = 1'b1;
        mark_raddr = rd_pos_reg[ADDR_W-1:0];
        q_we       = 1'b0;
        q_wdata    = {ny_reg, nx_reg};

        case (state_reg)
            // Mark-map clearing pass
            ST_CLEAR: begin
                mark_we       = 1'b1;
                mark_waddr    = clr_addr_reg;
                mark_wdata    = 1'b0;
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == '1) begin
                    state_next = fill_pending_reg ? ST_SCAN : ST_IDLE;
                end
            end

            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    if (s_cmd == htff_pkg::CMD_READ) begin
                        rd_pos_next = (read_count_reg >= total_reg) ? '0 : read_count_reg;
                        state_next  = ST_RD;
                    end else begin
                        // Pixel load; the last pixel arms the fill
                        pix_we = 1'b1;
                        if (load_count_reg == '0) begin
                            read_count_next = '0;
                        end
                        if (load_fill) begin
                            load_count_next = '0;
                            read_count_next = '0;
                            seed_scan_next  = '0;
                            seed_x_next     = '0;
                            seed_y_next     = '0;
                            head_next       = '0;
                            tail_next       = '0;
                        end else begin
                            load_count_next = load_inc;
                        end
                        fill_pending_next = load_fill;
                        if (load_count_reg == '0) begin
                            clr_addr_next = '0;
                            state_next    = ST_CLEAR;
                        end else if (load_fill) begin
                            state_next = ST_SCAN;
                        end
                    end
                end
            end

            ST_RD: begin
                state_next = ST_RDQ;
            end

            // Mark is back; hand it over once the output slot is free
            ST_RDQ: begin
                if (out_free) begin
                    m_valid_next     = 1'b1;
                    m_edge_mark_next = mark_q;
                    m_last_mark_next = rd_pos_reg == (total_reg - CNT_W'(1));
                    read_count_next  = (rd_inc >= total_reg) ? '0 : rd_inc;
                    state_next       = ST_IDLE;
                end
            end

            // Seed scan over the image
            ST_SCAN: begin
                pix_raddr  = seed_scan_reg[ADDR_W-1:0];
                mark_raddr = seed_scan_reg[ADDR_W-1:0];
                if (seed_scan_reg >= total_reg) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_SCANQ;
                end
            end

            ST_SCANQ: begin
                if (seed_ok) begin
                    mark_we    = 1'b1;
                    mark_waddr = seed_scan_reg[ADDR_W-1:0];
                    q_we       = 1'b1;
                    q_wdata    = {seed_y_reg, seed_x_reg};
                    tail_next  = tail_reg + CNT_W'(1);
                end
                state_next = ST_POP;
            end

            // Take the next queued pixel, or move the seed scan on
            ST_POP: begin
                if (head_reg == tail_reg) begin
                    seed_scan_next = seed_scan_reg + CNT_W'(1);
                    if ((DIM_W'(seed_x_reg) + DIM_W'(1)) == w_eff) begin
                        seed_x_next = '0;
                        seed_y_next = seed_y_reg + Y_W'(1);
                    end else begin
                        seed_x_next = seed_x_reg + X_W'(1);
                    end
                    state_next = ST_SCAN;
                end else begin
                    head_next  = head_reg + CNT_W'(1);
                    state_next = ST_POPQ;
                end
            end

            ST_POPQ: begin
                cx_next    = q_cx;
                cy_next    = q_cy;
                c_lin_next = CNT_W'(q_cy) * CNT_W'(w_eff) + CNT_W'(q_cx);
                state_next = ST_ROWS;
            end

            ST_ROWS: begin
                row_base_next[0] = c_lin_reg - CNT_W'(w_eff);
                row_base_next[1] = c_lin_reg;
                row_base_next[2] = c_lin_reg + CNT_W'(w_eff);
                nb_k_next        = '0;
                state_next       = ST_NB;
            end

            // Neighbor visit: read the neighbor, check it only if inside the image
            ST_NB: begin
                mark_raddr = nb_addr_full[ADDR_W-1:0];
                if (nb_in) begin
                    nb_addr_next = nb_addr_full[ADDR_W-1:0];
                    nx_next      = nx_s[X_W-1:0];
                    ny_next      = ny_s[Y_W-1:0];
                    state_next   = ST_NBQ;
                end else if (nb_k_reg == htff_pkg::NB_LAST) begin
                    state_next = ST_POP;
                end else begin
                    nb_k_next = nb_k_reg + 3'd1;
                end
            end

            ST_NBQ: begin
                if (nb_ok) begin
                    mark_we   = 1'b1;
                    q_we      = 1'b1;
                    tail_next = tail_reg + CNT_W'(1);
                end
                if (nb_k_reg == htff_pkg::NB_LAST) begin
                    state_next = ST_POP;
                end else begin
                    nb_k_next  = nb_k_reg + 3'd1;
                    state_next = ST_NB;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_CLEAR;
            clr_addr_reg     <= '0;
            fill_pending_reg <= 1'b0;
            load_count_reg   <= '0;
            read_count_reg   <= '0;
            seed_scan_reg    <= '0;
            seed_x_reg       <= '0;
            seed_y_reg       <= '0;
            head_reg         <= '0;
            tail_reg         <= '0;
            nb_k_reg         <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            clr_addr_reg     <= clr_addr_next;
            fill_pending_reg <= fill_pending_next;
            load_count_reg   <= load_count_next;
            read_count_reg   <= read_count_next;
            seed_scan_reg    <= seed_scan_next;
            seed_x_reg       <= seed_x_next;
            seed_y_reg       <= seed_y_next;
            head_reg         <= head_next;
            tail_reg         <= tail_next;
            nb_k_reg         <= nb_k_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        rd_pos_reg      <= rd_pos_next;
        cx_reg          <= cx_next;
        cy_reg          <= cy_next;
        c_lin_reg       <= c_lin_next;
        row_base_reg    <= row_base_next;
        nb_addr_reg     <= nb_addr_next;
        nx_reg          <= nx_next;
        ny_reg          <= ny_next;
        m_edge_mark_reg <= m_edge_mark_next;
        m_last_mark_reg <= m_last_mark_next;
    end

    // Pixel store
    always_ff @(posedge aclk) begin
        if (pix_we) begin
            pixel_mem[load_count_reg[ADDR_W-1:0]] <= s_pixel_value[PIX_W-1:0];
        end
        pix_q <= pixel_mem[pix_raddr];
    end

    // Mark map
    always_ff @(posedge aclk) begin
        if (mark_we) begin
            mark_mem[mark_waddr] <= mark_wdata;
        end
        mark_q <= mark_mem[mark_raddr];
    end

    // Work queue of marked pixel coordinates
    always_ff @(posedge aclk) begin
        if (q_we) begin
            queue_mem[tail_reg[ADDR_W-1:0]] <= q_wdata;
        end
        queue_q <= queue_mem[head_reg[ADDR_W-1:0]];
    end

endmodule

// File: sv/htff_checker.sv
module htff_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wen,
    input  logic                             s_valid,
    input  logic                             s_ready,
    input  logic                             s_cmd,
    input  logic                             m_valid,
    input  logic                             m_ready,
    input  logic                             m_edge_mark,
    input  logic                             m_last_mark
);

    logic read_accept;

    assign read_accept = s_valid && s_ready && (s_cmd == htff_pkg::CMD_READ);

    // Reset leaves no result and starts the clearing pass
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !s_ready)
        else $error("result or ready out of reset");

    // A stalled result holds its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_edge_mark) && $stable(m_last_mark))
        else $error("result changed while stalled");

    // A read transaction closes the input until its mark is handed to the output slot
    a_read_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        read_accept |=> !s_ready)
        else $error("input open during mark read");

    // With the output slot empty at acceptance, the mark is offered once the read has passed ST_RD and ST_RDQ
    a_read_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        read_accept && !m_valid |-> ##3 m_valid)
        else $error("read transaction produced no result");

    // The input is closed in the cycle after a register write while the pixel count settles
    a_cfg_settle: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wen |=> !s_ready)
        else $error("input open right after register write");

endmodule

bind hysteresis_threshold_flood_fill htff_checker u_htff_checker (.*);
